>>> hw/rtl/rme_pkg.sv
// ----------------------------------------------------------------------------
// Register machine executor package
// Shared codes, default sizes and payload types of the executor.
// ----------------------------------------------------------------------------
package rme_pkg;

    localparam int RME_NUM_REGS   = 26;
    localparam int RME_MEM_DEPTH  = 16384;
    localparam int RME_PROG_DEPTH = 4096;

    localparam int WORD_W = 32;
    localparam int IDX_W  = 12;

    localparam logic [2:0] OP_ASSIGN = 3'd0;
    localparam logic [2:0] OP_GOTO   = 3'd1;
    localparam logic [2:0] OP_IFGOTO = 3'd2;
    localparam logic [2:0] OP_ARITH  = 3'd3;
    localparam logic [2:0] OP_INPUT  = 3'd4;
    localparam logic [2:0] OP_OUTPUT = 3'd5;
    localparam logic [2:0] OP_HALT   = 3'd6;

    localparam logic [3:0] ALU_ADD = 4'd0;
    localparam logic [3:0] ALU_SUB = 4'd1;
    localparam logic [3:0] ALU_MUL = 4'd2;
    localparam logic [3:0] ALU_DIV = 4'd3;
    localparam logic [3:0] ALU_EQ  = 4'd4;
    localparam logic [3:0] ALU_NE  = 4'd5;
    localparam logic [3:0] ALU_LT  = 4'd6;
    localparam logic [3:0] ALU_GT  = 4'd7;
    localparam logic [3:0] ALU_GE  = 4'd8;
    localparam logic [3:0] ALU_LE  = 4'd9;

    localparam logic [1:0] KIND_IMM  = 2'd0;
    localparam logic [1:0] KIND_REG  = 2'd1;
    localparam logic [1:0] KIND_MEM  = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd0;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_RANGE   = 2'd1;
    localparam logic [1:0] STATUS_DIVZERO = 2'd2;

    typedef struct packed {
        logic [2:0]         operation;
        logic [3:0]         alu_op;
        logic [1:0]         dest_kind;
        logic [4:0]         dest_reg;
        logic [1:0]         a_kind;
        logic signed [31:0] a_operand;
        logic [1:0]         b_kind;
        logic signed [31:0] b_operand;
        logic [11:0]        jump_target;
        logic signed [31:0] in_value;
        logic               in_present;
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic need_a;
        logic need_b;
    } dec_t;

endpackage

>>> hw/rtl/rme_if.sv
// ----------------------------------------------------------------------------
// Register machine executor channels
// Instruction channel and result channel, each with valid and ready.
// ----------------------------------------------------------------------------
interface rme_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic [3:0]         alu_op;
    logic [1:0]         dest_kind;
    logic [4:0]         dest_reg;
    logic [1:0]         a_kind;
    logic signed [31:0] a_operand;
    logic [1:0]         b_kind;
    logic signed [31:0] b_operand;
    logic [11:0]        jump_target;
    logic signed [31:0] in_value;
    logic               in_present;

    modport source (output valid, operation, alu_op, dest_kind, dest_reg, a_kind, a_operand,
                    b_kind, b_operand, jump_target, in_value, in_present, input ready);
    modport sink (input valid, operation, alu_op, dest_kind, dest_reg, a_kind, a_operand,
                  b_kind, b_operand, jump_target, in_value, in_present, output ready);
endinterface

interface rme_res_if;
    logic               valid;
    logic               ready;
    logic [11:0]        next_index;
    logic               halted;
    logic               out_valid;
    logic signed [31:0] out_value;
    logic [1:0]         status;

    modport source (output valid, next_index, halted, out_valid, out_value, status,
                    input ready);
    modport sink (input valid, next_index, halted, out_valid, out_value, status,
                  output ready);
endinterface

>>> hw/rtl/rme_front.sv
// ----------------------------------------------------------------------------
// Register machine executor front end
// Takes instruction beats, classifies their operand needs and hands them on.
// ----------------------------------------------------------------------------
module rme_front (
    input  logic          clk,
    input  logic          rst_n,
    rme_cmd_if.sink       cmd,
    input  logic          init_done,
    output logic          q_push,
    output rme_pkg::dec_t q_data,
    input  logic          q_ready
);
    import rme_pkg::*;

    logic stage_v_reg;
    logic stage_v_next;
    dec_t stage_reg;
    dec_t stage_next;
    logic accept;

    assign cmd.ready = init_done && (!stage_v_reg || q_ready);
    assign accept    = cmd.valid && cmd.ready;
    assign q_push    = stage_v_reg;
    assign q_data    = stage_reg;

    always_comb
    begin
        stage_next.cmd.operation   = cmd.operation;
        stage_next.cmd.alu_op      = cmd.alu_op;
        stage_next.cmd.dest_kind   = cmd.dest_kind;
        stage_next.cmd.dest_reg    = cmd.dest_reg;
        stage_next.cmd.a_kind      = cmd.a_kind;
        stage_next.cmd.a_operand   = cmd.a_operand;
        stage_next.cmd.b_kind      = cmd.b_kind;
        stage_next.cmd.b_operand   = cmd.b_operand;
        stage_next.cmd.jump_target = cmd.jump_target;
        stage_next.cmd.in_value    = cmd.in_value;
        stage_next.cmd.in_present  = cmd.in_present;
        stage_next.need_a = (cmd.operation == OP_ASSIGN) || (cmd.operation == OP_ARITH) ||
                            (cmd.operation == OP_OUTPUT) ||
                            ((cmd.operation == OP_IFGOTO) && (cmd.a_kind == KIND_REG));
        stage_next.need_b = (cmd.operation == OP_ARITH);
        stage_v_next = accept || (stage_v_reg && !q_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_v_reg <= 1'b0;
        end
        else
        begin
            stage_v_reg <= stage_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

>>> hw/rtl/rme_queue.sv
// ----------------------------------------------------------------------------
// Register machine executor queue
// Two-entry queue between the front end and the execution sequencer.
// ----------------------------------------------------------------------------
module rme_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rme_pkg::dec_t push_data,
    output logic          push_ready,
    input  logic          pop,
    output logic          pop_valid,
    output rme_pkg::dec_t pop_data
);
    import rme_pkg::*;

    dec_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hw/rtl/rme_div.sv
// ----------------------------------------------------------------------------
// Register machine executor divider
// Signed restoring divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module rme_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    import rme_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [32:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] den_reg;
    logic        neg_reg;
    logic [32:0] rem_sh;
    logic        take;

    assign rem_sh   = {rem_reg[31:0], quo_reg[31]};
    assign take     = (rem_sh >= {1'b0, den_reg});
    assign done     = done_reg;
    assign quotient = neg_reg ? (32'd0 - quo_reg) : quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= 33'd0;
            quo_reg <= dividend[31] ? (32'd0 - dividend) : dividend;
            den_reg <= divisor[31] ? (32'd0 - divisor) : divisor;
            neg_reg <= dividend[31] ^ divisor[31];
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            quo_reg <= {quo_reg[30:0], take};
        end
    end

endmodule

>>> hw/rtl/rme_back.sv
// ----------------------------------------------------------------------------
// Register machine executor back end
// Sequencer that fetches operands, computes, stores and issues the result.
// ----------------------------------------------------------------------------
module rme_back #(
    parameter int NUM_REGS   = rme_pkg::RME_NUM_REGS,
    parameter int MEM_DEPTH  = rme_pkg::RME_MEM_DEPTH,
    parameter int PROG_DEPTH = rme_pkg::RME_PROG_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  rme_pkg::dec_t q_data,
    output logic          q_pop,
    output logic          init_done,
    rme_res_if.source     res
);
    import rme_pkg::*;

    localparam int RAW  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int MAW  = $clog2(MEM_DEPTH);
    localparam int PCW  = $clog2(PROG_DEPTH);
    localparam int MODW = IDX_W + 18;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_FETCH = 4'd2;
    localparam logic [3:0] S_FREG  = 4'd3;
    localparam logic [3:0] S_FMEM  = 4'd4;
    localparam logic [3:0] S_EXEC  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_STORE = 4'd7;
    localparam logic [3:0] S_SREG  = 4'd8;
    localparam logic [3:0] S_MOD   = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    logic [3:0]          state_reg, state_next;
    logic [MAW-1:0]      clr_reg, clr_next;
    dec_t                it_reg, it_next;
    logic                slot_b_reg, slot_b_next;
    logic [31:0]         a_reg, a_next;
    logic [31:0]         b_reg, b_next;
    logic                ok_reg, ok_next;
    logic                fault_reg, fault_next;
    logic                divz_reg, divz_next;
    logic                outv_reg, outv_next;
    logic [31:0]         outval_reg, outval_next;
    logic                jmp_reg, jmp_next;
    logic                hop_reg, hop_next;
    logic [IDX_W-1:0]    tgt_reg, tgt_next;
    logic [3:0]          k_reg, k_next;
    logic [1:0]          st_kind_reg, st_kind_next;
    logic [31:0]         st_opnd_reg, st_opnd_next;
    logic [31:0]         st_val_reg, st_val_next;
    logic                st2_v_reg, st2_v_next;
    logic [1:0]          st2_kind_reg, st2_kind_next;
    logic [31:0]         st2_opnd_reg, st2_opnd_next;
    logic [31:0]         st2_val_reg, st2_val_next;
    logic [PCW-1:0]      pc_reg, pc_next;
    logic                halt_reg, halt_next;
    logic                res_v_reg, res_v_next;
    logic [IDX_W-1:0]    res_idx_reg, res_idx_next;
    logic                res_halt_reg, res_halt_next;
    logic                res_outv_reg, res_outv_next;
    logic [31:0]         res_outval_reg, res_outval_next;
    logic [1:0]          res_status_reg, res_status_next;
    logic                res_load;

    logic [31:0]         rf_mem [NUM_REGS];
    logic [NUM_REGS-1:0] rf_valid_reg;
    logic [31:0]         rf_q_reg;
    logic                rf_hit_reg;
    logic                rf_re;
    logic [31:0]         rf_ropnd;
    logic                rf_rin;
    logic [RAW-1:0]      rf_ra;
    logic                rf_we;
    logic [RAW-1:0]      rf_wa;
    logic [31:0]         rf_wd;
    logic [31:0]         rv;

    logic [31:0]         dmem [MEM_DEPTH];
    logic [31:0]         mem_q_reg;
    logic                mem_we;
    logic [MAW-1:0]      mem_wa;
    logic [31:0]         mem_wd;
    logic [MAW-1:0]      mem_ra;

    logic                div_start;
    logic                div_done;
    logic [31:0]         div_q;

    logic [1:0]          cur_kind;
    logic [31:0]         cur_opnd;
    logic                fdone;
    logic [31:0]         fval;
    logic                sdone;
    logic [31:0]         alu_r;
    logic                alu_wr;
    logic [PCW-1:0]      pc_seq;
    logic [PCW-1:0]      pc_new;
    logic [MODW-1:0]     mod_sh;
    logic                dest_used;

    rme_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (a_reg),
        .divisor  (b_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign init_done = (state_reg != S_CLR);
    assign rv        = rf_hit_reg ? rf_q_reg : 32'd0;
    assign cur_kind  = slot_b_reg ? it_reg.cmd.b_kind : it_reg.cmd.a_kind;
    assign cur_opnd  = slot_b_reg ? it_reg.cmd.b_operand : it_reg.cmd.a_operand;
    assign pc_seq    = (pc_reg == PCW'(PROG_DEPTH - 1)) ? '0 : pc_reg + PCW'(1);
    assign mod_sh    = MODW'(PROG_DEPTH) << k_reg;
    assign rf_rin    = (rf_ropnd < 32'(NUM_REGS));
    assign rf_ra     = rf_rin ? rf_ropnd[RAW-1:0] : '0;
    assign dest_used = (it_reg.cmd.dest_kind == KIND_REG) ||
                       (it_reg.cmd.dest_kind == KIND_MEM);

    assign res.valid      = res_v_reg;
    assign res.next_index = res_idx_reg;
    assign res.halted     = res_halt_reg;
    assign res.out_valid  = res_outv_reg;
    assign res.out_value  = res_outval_reg;
    assign res.status     = res_status_reg;

    always_comb
    begin
        alu_wr = 1'b1;
        alu_r  = 32'd0;
        case (it_reg.cmd.alu_op)
            ALU_ADD: alu_r = a_reg + b_reg;
            ALU_SUB: alu_r = a_reg - b_reg;
            ALU_MUL: alu_r = a_reg * b_reg;
            ALU_EQ:  alu_r = 32'($signed(a_reg) == $signed(b_reg));
            ALU_NE:  alu_r = 32'($signed(a_reg) != $signed(b_reg));
            ALU_LT:  alu_r = 32'($signed(a_reg) < $signed(b_reg));
            ALU_GT:  alu_r = 32'($signed(a_reg) > $signed(b_reg));
            ALU_GE:  alu_r = 32'($signed(a_reg) >= $signed(b_reg));
            ALU_LE:  alu_r = 32'($signed(a_reg) <= $signed(b_reg));
            default: alu_wr = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        it_next         = it_reg;
        slot_b_next     = slot_b_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        ok_next         = ok_reg;
        fault_next      = fault_reg;
        divz_next       = divz_reg;
        outv_next       = outv_reg;
        outval_next     = outval_reg;
        jmp_next        = jmp_reg;
        hop_next        = hop_reg;
        tgt_next        = tgt_reg;
        k_next          = k_reg;
        st_kind_next    = st_kind_reg;
        st_opnd_next    = st_opnd_reg;
        st_val_next     = st_val_reg;
        st2_v_next      = st2_v_reg;
        st2_kind_next   = st2_kind_reg;
        st2_opnd_next   = st2_opnd_reg;
        st2_val_next    = st2_val_reg;
        pc_next         = pc_reg;
        halt_next       = halt_reg;
        res_idx_next    = res_idx_reg;
        res_halt_next   = res_halt_reg;
        res_outv_next   = res_outv_reg;
        res_outval_next = res_outval_reg;
        res_status_next = res_status_reg;
        res_load        = 1'b0;
        q_pop           = 1'b0;
        rf_re           = 1'b0;
        rf_ropnd        = cur_opnd;
        rf_we           = 1'b0;
        rf_wa           = st_opnd_reg[RAW-1:0];
        rf_wd           = st_val_reg;
        mem_we          = 1'b0;
        mem_wa          = clr_reg;
        mem_wd          = st_val_reg;
        mem_ra          = rv[MAW-1:0];
        div_start       = 1'b0;
        fdone           = 1'b0;
        fval            = 32'd0;
        sdone           = 1'b0;
        pc_new          = pc_seq;

        case (state_reg)
            S_CLR:
            begin
                mem_we   = 1'b1;
                mem_wd   = 32'd0;
                clr_next = clr_reg + MAW'(1);
                if (clr_reg == MAW'(MEM_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop        = 1'b1;
                    it_next      = q_data;
                    slot_b_next  = 1'b0;
                    a_next       = 32'd0;
                    b_next       = 32'd0;
                    ok_next      = 1'b1;
                    fault_next   = 1'b0;
                    divz_next    = 1'b0;
                    outv_next    = 1'b0;
                    outval_next  = 32'd0;
                    jmp_next     = 1'b0;
                    hop_next     = 1'b0;
                    tgt_next     = q_data.cmd.jump_target;
                    k_next       = 4'(IDX_W - 1);
                    st_kind_next = KIND_NONE;
                    st2_v_next   = 1'b0;
                    if (halt_reg)
                    begin
                        state_next = S_FIN;
                    end
                    else if (q_data.need_a)
                    begin
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_FETCH:
            begin
                if (cur_kind == KIND_IMM)
                begin
                    fval  = cur_opnd;
                    fdone = 1'b1;
                end
                else if ((cur_kind == KIND_REG) || (cur_kind == KIND_MEM))
                begin
                    rf_re      = 1'b1;
                    state_next = S_FREG;
                end
                else
                begin
                    fdone = 1'b1;
                end
            end
            S_FREG:
            begin
                if (cur_kind == KIND_REG)
                begin
                    fval  = rv;
                    fdone = 1'b1;
                end
                else if (rv >= 32'(MEM_DEPTH))
                begin
                    fault_next = 1'b1;
                    ok_next    = 1'b0;
                    fdone      = 1'b1;
                end
                else
                begin
                    state_next = S_FMEM;
                end
            end
            S_FMEM:
            begin
                fval  = mem_q_reg;
                fdone = 1'b1;
            end
            S_EXEC:
            begin
                state_next    = S_STORE;
                st_kind_next  = it_reg.cmd.dest_kind;
                st_opnd_next  = 32'(it_reg.cmd.dest_reg);
                st_val_next   = a_reg;
                case (it_reg.cmd.operation)
                    OP_ASSIGN:
                    begin
                        if (!ok_reg)
                        begin
                            st_kind_next = KIND_NONE;
                        end
                    end
                    OP_GOTO:
                    begin
                        st_kind_next = KIND_NONE;
                        jmp_next     = 1'b1;
                    end
                    OP_IFGOTO:
                    begin
                        st_kind_next = KIND_NONE;
                        jmp_next     = (it_reg.cmd.a_kind == KIND_REG) && (a_reg != 32'd0);
                    end
                    OP_ARITH:
                    begin
                        st_val_next = alu_r;
                        if (it_reg.cmd.alu_op == ALU_DIV)
                        begin
                            st_kind_next = KIND_NONE;
                            if (b_reg == 32'd0)
                            begin
                                divz_next = 1'b1;
                            end
                            else if (ok_reg)
                            begin
                                div_start  = 1'b1;
                                state_next = S_DIV;
                            end
                        end
                        else if (!(ok_reg && alu_wr))
                        begin
                            st_kind_next = KIND_NONE;
                        end
                    end
                    OP_INPUT:
                    begin
                        st_val_next   = it_reg.cmd.in_value;
                        if (!(dest_used && it_reg.cmd.in_present))
                        begin
                            st_kind_next = KIND_NONE;
                        end
                        st2_v_next    = 1'b1;
                        st2_kind_next = it_reg.cmd.a_kind;
                        st2_opnd_next = it_reg.cmd.a_operand;
                        st2_val_next  = 32'(dest_used && !it_reg.cmd.in_present);
                    end
                    OP_OUTPUT:
                    begin
                        st_kind_next = KIND_NONE;
                        if ((it_reg.cmd.a_kind != 2'd3) && ok_reg)
                        begin
                            outv_next   = 1'b1;
                            outval_next = a_reg;
                        end
                    end
                    OP_HALT:
                    begin
                        st_kind_next = KIND_NONE;
                        hop_next     = 1'b1;
                    end
                    default:
                    begin
                        st_kind_next = KIND_NONE;
                    end
                endcase
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    st_kind_next = it_reg.cmd.dest_kind;
                    st_val_next  = div_q;
                    state_next   = S_STORE;
                end
            end
            S_STORE:
            begin
                rf_ropnd = st_opnd_reg;
                if (st_kind_reg == KIND_REG)
                begin
                    rf_we = (st_opnd_reg < 32'(NUM_REGS));
                    sdone = 1'b1;
                end
                else if (st_kind_reg == KIND_MEM)
                begin
                    rf_re      = 1'b1;
                    state_next = S_SREG;
                end
                else
                begin
                    sdone = 1'b1;
                end
            end
            S_SREG:
            begin
                if (rv >= 32'(MEM_DEPTH))
                begin
                    fault_next = 1'b1;
                end
                else
                begin
                    mem_we = 1'b1;
                    mem_wa = rv[MAW-1:0];
                end
                sdone = 1'b1;
            end
            S_MOD:
            begin
                if (jmp_reg && (MODW'(tgt_reg) >= MODW'(PROG_DEPTH)))
                begin
                    if (MODW'(tgt_reg) >= mod_sh)
                    begin
                        tgt_next = tgt_reg - IDX_W'(mod_sh);
                    end
                    k_next = k_reg - 4'd1;
                    if (k_reg == 4'd0)
                    begin
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (halt_reg || hop_reg)
                begin
                    pc_new = pc_reg;
                end
                else if (jmp_reg)
                begin
                    pc_new = PCW'(tgt_reg);
                end
                if (!res_v_reg || res.ready)
                begin
                    res_load        = 1'b1;
                    pc_next         = pc_new;
                    halt_next       = halt_reg || hop_reg;
                    res_idx_next    = IDX_W'(pc_new);
                    res_halt_next   = halt_reg || hop_reg;
                    res_outv_next   = outv_reg;
                    res_outval_next = outv_reg ? outval_reg : 32'd0;
                    res_status_next = fault_reg ? STATUS_RANGE :
                                      (divz_reg ? STATUS_DIVZERO : STATUS_OK);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fdone)
        begin
            if (slot_b_reg)
            begin
                b_next = fval;
            end
            else
            begin
                a_next = fval;
            end
            if (!slot_b_reg && it_reg.need_b)
            begin
                slot_b_next = 1'b1;
                state_next  = S_FETCH;
            end
            else
            begin
                state_next = S_EXEC;
            end
        end

        if (sdone)
        begin
            if (st2_v_reg)
            begin
                st2_v_next   = 1'b0;
                st_kind_next = st2_kind_reg;
                st_opnd_next = st2_opnd_reg;
                st_val_next  = st2_val_reg;
                state_next   = S_STORE;
            end
            else
            begin
                state_next = S_MOD;
            end
        end

        res_v_next = res_load || (res_v_reg && !res.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            clr_reg      <= '0;
            pc_reg       <= '0;
            halt_reg     <= 1'b0;
            res_v_reg    <= 1'b0;
            rf_valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pc_reg    <= pc_next;
            halt_reg  <= halt_next;
            res_v_reg <= res_v_next;
            if (rf_we)
            begin
                rf_valid_reg[rf_wa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg         <= it_next;
        slot_b_reg     <= slot_b_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        ok_reg         <= ok_next;
        fault_reg      <= fault_next;
        divz_reg       <= divz_next;
        outv_reg       <= outv_next;
        outval_reg     <= outval_next;
        jmp_reg        <= jmp_next;
        hop_reg        <= hop_next;
        tgt_reg        <= tgt_next;
        k_reg          <= k_next;
        st_kind_reg    <= st_kind_next;
        st_opnd_reg    <= st_opnd_next;
        st_val_reg     <= st_val_next;
        st2_v_reg      <= st2_v_next;
        st2_kind_reg   <= st2_kind_next;
        st2_opnd_reg   <= st2_opnd_next;
        st2_val_reg    <= st2_val_next;
        res_idx_reg    <= res_idx_next;
        res_halt_reg   <= res_halt_next;
        res_outv_reg   <= res_outv_next;
        res_outval_reg <= res_outval_next;
        res_status_reg <= res_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[rf_wa] <= rf_wd;
        end
        if (rf_re)
        begin
            rf_q_reg   <= rf_mem[rf_ra];
            rf_hit_reg <= rf_rin && rf_valid_reg[rf_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dmem[mem_wa] <= mem_wd;
        end
        mem_q_reg <= dmem[mem_ra];
    end

`ifndef SYNTHESIS
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == S_IDLE)
        else $error("queue popped outside the idle state");

    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished while not awaited");

    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_CLR |=> state_reg != S_CLR)
        else $error("memory clearing restarted");

    a_halt_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(halt_reg) |-> $past(res_load))
        else $error("halt taken without a result");

    a_mem_write: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg != S_CLR) |-> state_reg == S_SREG)
        else $error("stray data memory write");
`endif

endmodule

>>> hw/rtl/register_machine_executor.sv
// ----------------------------------------------------------------------------
// Register machine executor
// Executes one decoded register machine instruction per instruction beat.
// ----------------------------------------------------------------------------
// After reset the data memory is cleared one word per cycle, and no instruction
// beat is taken until that pass ends. Instructions then run one at a time in the
// execution sequencer: a jump or halt passes the idle, execute, store, modulo and
// finish states; a register operand adds a fetch and a register read, a memory
// operand also a memory read; a memory store adds an address read, an input a
// second store for its end flag, a jump target beyond the program size modulo
// steps, and a divide a wait on the bit-serial divider. A two-entry queue and an
// input stage let the front end take beats while the sequencer works, and a
// result register lets it finish while a result beat waits.
module register_machine_executor #(
    parameter int NUM_REGS   = rme_pkg::RME_NUM_REGS,
    parameter int MEM_DEPTH  = rme_pkg::RME_MEM_DEPTH,
    parameter int PROG_DEPTH = rme_pkg::RME_PROG_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    rme_cmd_if.sink   cmd,
    rme_res_if.source res
);
    import rme_pkg::*;

    logic init_done;
    logic f_push;
    dec_t f_data;
    logic f_ready;
    logic q_pop;
    logic q_valid;
    dec_t q_data;

    rme_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .init_done (init_done),
        .q_push    (f_push),
        .q_data    (f_data),
        .q_ready   (f_ready)
    );

    rme_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (f_push),
        .push_data  (f_data),
        .push_ready (f_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_data   (q_data)
    );

    rme_back #(
        .NUM_REGS   (NUM_REGS),
        .MEM_DEPTH  (MEM_DEPTH),
        .PROG_DEPTH (PROG_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .init_done (init_done),
        .res       (res)
    );

endmodule
